/* rtl/core/tcw_pkg.sv */
// shared types and constants for the text console character writer
package tcw_pkg;

   // geometry defaults for the top-level parameters
   localparam int DEF_MAX_COLUMNS = 128;
   localparam int DEF_MAX_ROWS    = 64;

   // register reset values
   localparam int         RESET_COLS = 80;
   localparam int         RESET_ROWS = 25;
   localparam logic [7:0] RESET_ATTR = 8'h35;

   // cell layout: attribute in the high byte, character in the low byte
   localparam int         CELL_W     = 16;
   localparam logic [7:0] SPACE_CODE = 8'h20;

   // character codes with a special meaning
   localparam logic [7:0] CH_NUL = 8'h00;
   localparam logic [7:0] CH_BEL = 8'h07;
   localparam logic [7:0] CH_BS  = 8'h08;
   localparam logic [7:0] CH_TAB = 8'h09;
   localparam logic [7:0] CH_LF  = 8'h0A;
   localparam logic [7:0] CH_CR  = 8'h0D;

   localparam int TAB_MASK = 7;
   localparam int TAB_STOP = TAB_MASK + 1;

   // request kinds
   localparam logic [1:0] REQ_PUT  = 2'd0;
   localparam logic [1:0] REQ_READ = 2'd1;
   localparam logic [1:0] REQ_TAKE = 2'd2;

   // register map, index = byte address / 4
   localparam int         CSR_ADDR_W = 4;
   localparam logic [1:0] REG_COLS   = 2'd0;
   localparam logic [1:0] REG_ROWS   = 2'd1;
   localparam logic [1:0] REG_ATTR   = 2'd2;

   typedef struct packed {
      logic [7:0] attr;
      logic [6:0] rows;
      logic [7:0] cols;
   } cfg_type;

   typedef struct packed {
      logic mark;
      logic clear;
   } dirty_cmd_type;

endpackage

/* rtl/core/text_console_char_writer.sv */
// text console character writer: request sequencer, scroll walker and result register
// accepted beat to result: a take or an ignored code passes S_EXEC and S_DONE, an in-range
// read adds S_READ, a plain put adds S_MARK_PREV and S_MARK_NEW; S_DONE holds on rsp stalls
// a scrolling put copies every cell below the top row one row up (S_SCR_RD, then S_SCR_WR)
// and blanks the last row in S_BLANK; one request is in work at a time
// reset: store cleared to space/0x35 over all MAX_ROWS*2^clog2(MAX_COLUMNS) addresses (8192)
module text_console_char_writer
   import tcw_pkg::*;
   #(
      parameter int MAX_COLUMNS = DEF_MAX_COLUMNS,
      parameter int MAX_ROWS    = DEF_MAX_ROWS
   )
   (
      input  logic                  clock,
      input  logic                  reset,
      // request channel
      input  logic                  req_tvalid,
      output logic                  req_tready,
      input  logic [23:0]           req_tdata,  // char_code[7:0], read_col[14:8], read_row[20:15]
      input  logic [1:0]            req_tuser,  // req_type[1:0]
      // result channel
      output logic                  rsp_tvalid,
      input  logic                  rsp_tready,
      output logic [63:0]           rsp_tdata,  // cursor_col[6:0], cursor_row[12:7],
                                                // cell_value[28:13], dirty_left[36:29],
                                                // dirty_top[43:37], dirty_right[51:44],
                                                // dirty_bottom[58:52], dirty_any[59]
      // configuration port
      input  logic                  csr_psel,
      input  logic                  csr_penable,
      input  logic                  csr_pwrite,
      input  logic [CSR_ADDR_W-1:0] csr_paddr,
      input  logic [31:0]           csr_pwdata,
      output logic [31:0]           csr_prdata,
      output logic                  csr_pready
   );

   localparam int COL_W  = $clog2(MAX_COLUMNS);
   localparam int ROW_W  = $clog2(MAX_ROWS);
   localparam int CX_W   = COL_W + 1;
   localparam int CY_W   = ROW_W + 1;
   localparam int ADDR_W = COL_W + ROW_W;
   localparam int DEPTH  = MAX_ROWS * (2 ** COL_W);

   // sequencer states, one-hot
   typedef enum logic [9:0] {
      S_CLEAR     = 10'b0000000001,
      S_IDLE      = 10'b0000000010,
      S_EXEC      = 10'b0000000100,
      S_READ      = 10'b0000001000,
      S_SCR_RD    = 10'b0000010000,
      S_SCR_WR    = 10'b0000100000,
      S_BLANK     = 10'b0001000000,
      S_MARK_PREV = 10'b0010000000,
      S_MARK_NEW  = 10'b0100000000,
      S_DONE      = 10'b1000000000
   } state_type;

   state_type state_ff, state_in;

   // configuration
   cfg_type cfg;

   // latched request beat
   logic [1:0] type_ff, type_in;
   logic [7:0] char_ff, char_in;
   logic [6:0] rcol_ff, rcol_in;
   logic [5:0] rrow_ff, rrow_in;

   // cursor and previous cursor
   logic [COL_W-1:0] cursor_x_ff, cursor_x_in, prev_x_ff, prev_x_in;
   logic [ROW_W-1:0] cursor_y_ff, cursor_y_in, prev_y_ff, prev_y_in;

   // clear pass and scroll walker counters
   logic [ADDR_W-1:0] clr_addr_ff, clr_addr_in;
   logic [COL_W-1:0]  scr_col_ff, scr_col_in;
   logic [ROW_W-1:0]  scr_row_ff, scr_row_in;

   logic [CELL_W-1:0] cell_ff, cell_in;

   // result register
   logic        rsp_valid_ff, rsp_valid_in;
   logic [63:0] rsp_data_ff, rsp_data_in;

   // store port
   logic              wr_en, rd_en;
   logic [ADDR_W-1:0] wr_addr, rd_addr;
   logic [CELL_W-1:0] wr_data, rd_data;

   // dirty rectangle unit
   dirty_cmd_type    dcmd;
   logic [COL_W-1:0] mark_x;
   logic [ROW_W-1:0] mark_y;
   logic [CX_W-1:0]  mark_x_end, d_left, d_right;
   logic [CY_W-1:0]  mark_y_end, d_top, d_bottom;

   // effective geometry
   logic [CX_W-1:0]  cols_eff;
   logic [CY_W-1:0]  rows_eff;
   logic [COL_W-1:0] cols_m1;
   logic [ROW_W-1:0] rows_m1;

   // put decode
   logic [COL_W-1:0] cx, put_x;
   logic [ROW_W-1:0] cy, put_y;
   logic [CX_W-1:0]  x_inc, tab_next;
   logic [CY_W-1:0]  y_inc;
   logic             put_write, put_scroll, put_ignore, line_down;
   logic             rd_in_range, out_load;

   tcw_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .pready  (csr_pready),
      .cfg     (cfg)
   );

   tcw_ram #(
      .WIDTH (CELL_W),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   tcw_dirty #(
      .MAX_COLUMNS (MAX_COLUMNS),
      .MAX_ROWS    (MAX_ROWS)
   ) u_dirty (
      .clock      (clock),
      .reset      (reset),
      .cmd        (dcmd),
      .mark_x     (mark_x),
      .mark_y     (mark_y),
      .mark_x_end (mark_x_end),
      .mark_y_end (mark_y_end),
      .left       (d_left),
      .top        (d_top),
      .right      (d_right),
      .bottom     (d_bottom)
   );

   // zero acts as one, anything above the maximum acts as the maximum
   always_comb begin
      if (cfg.cols == 8'd0) begin
         cols_eff = CX_W'(1);
      end else if (9'(cfg.cols) > 9'(MAX_COLUMNS)) begin
         cols_eff = CX_W'(MAX_COLUMNS);
      end else begin
         cols_eff = CX_W'(cfg.cols);
      end
      if (cfg.rows == 7'd0) begin
         rows_eff = CY_W'(1);
      end else if (8'(cfg.rows) > 8'(MAX_ROWS)) begin
         rows_eff = CY_W'(MAX_ROWS);
      end else begin
         rows_eff = CY_W'(cfg.rows);
      end
   end

   assign cols_m1 = COL_W'(cols_eff - 1'b1);
   assign rows_m1 = ROW_W'(rows_eff - 1'b1);

   // cursor move for one put character; the cursor is first pulled back inside
   // the screen in case the geometry shrank
   always_comb begin
      cx         = (CX_W'(cursor_x_ff) >= cols_eff) ? cols_m1 : cursor_x_ff;
      cy         = (CY_W'(cursor_y_ff) >= rows_eff) ? rows_m1 : cursor_y_ff;
      put_x      = cx;
      put_y      = cy;
      put_write  = 1'b0;
      put_scroll = 1'b0;
      line_down  = 1'b0;
      put_ignore = (char_ff == CH_NUL) || (char_ff == CH_BEL);
      x_inc      = CX_W'(cx) + 1'b1;
      y_inc      = CY_W'(cy) + 1'b1;
      tab_next   = {1'b0, cx & ~COL_W'(TAB_MASK)} + CX_W'(TAB_STOP);
      case (char_ff)
         CH_LF: begin
            line_down = 1'b1;
         end
         CH_CR: begin
            put_x = '0;
         end
         CH_BS: begin
            if (cx != '0) put_x = cx - 1'b1;
         end
         CH_TAB: begin
            // next tab stop, but never past the last column
            if (cx < cols_m1) begin
               put_x = (tab_next > CX_W'(cols_m1)) ? cols_m1 : COL_W'(tab_next);
            end
         end
         default: begin
            put_write = 1'b1;
            if (x_inc >= cols_eff) begin
               put_x     = '0;
               line_down = 1'b1;
            end else begin
               put_x = COL_W'(x_inc);
            end
         end
      endcase
      if (line_down) begin
         if (y_inc >= rows_eff) begin
            put_scroll = 1'b1;
            put_y      = rows_m1;
         end else begin
            put_y = ROW_W'(y_inc);
         end
      end
   end

   assign rd_in_range = (9'(rcol_ff) < 9'(cols_eff)) && (8'(rrow_ff) < 8'(rows_eff));
   assign out_load    = !rsp_valid_ff || rsp_tready;

   // sequencer
   always_comb begin
      state_in    = state_ff;
      type_in     = type_ff;
      char_in     = char_ff;
      rcol_in     = rcol_ff;
      rrow_in     = rrow_ff;
      cursor_x_in = cursor_x_ff;
      cursor_y_in = cursor_y_ff;
      prev_x_in   = prev_x_ff;
      prev_y_in   = prev_y_ff;
      clr_addr_in = clr_addr_ff;
      scr_col_in  = scr_col_ff;
      scr_row_in  = scr_row_ff;
      cell_in     = cell_ff;
      rsp_data_in = rsp_data_ff;
      rsp_valid_in = (rsp_valid_ff && !rsp_tready);

      wr_en      = 1'b0;
      wr_addr    = '0;
      wr_data    = '0;
      rd_en      = 1'b0;
      rd_addr    = '0;
      dcmd       = '0;
      mark_x     = '0;
      mark_y     = '0;
      mark_x_end = '0;
      mark_y_end = '0;

      case (state_ff)
         S_CLEAR: begin
            // reset value of every cell, one address a cycle
            wr_en       = 1'b1;
            wr_addr     = clr_addr_ff;
            wr_data     = {RESET_ATTR, SPACE_CODE};
            clr_addr_in = clr_addr_ff + 1'b1;
            if (clr_addr_ff == ADDR_W'(DEPTH - 1)) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_tvalid) begin
               type_in  = req_tuser;
               char_in  = req_tdata[7:0];
               rcol_in  = req_tdata[14:8];
               rrow_in  = req_tdata[20:15];
               cell_in  = '0;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            case (type_ff)
               REQ_PUT: begin
                  if (put_ignore) begin
                     state_in = S_DONE;
                  end else begin
                     cursor_x_in = put_x;
                     cursor_y_in = put_y;
                     if (put_write) begin
                        wr_en      = 1'b1;
                        wr_addr    = {cy, cx};
                        wr_data    = {cfg.attr, char_ff};
                        dcmd.mark  = 1'b1;
                        mark_x     = cx;
                        mark_y     = cy;
                        mark_x_end = x_inc;
                        mark_y_end = y_inc;
                     end
                     scr_col_in = '0;
                     scr_row_in = ROW_W'(1);
                     if (!put_scroll) begin
                        state_in = S_MARK_PREV;
                     end else if (rows_eff == CY_W'(1)) begin
                        state_in = S_BLANK;
                     end else begin
                        state_in = S_SCR_RD;
                     end
                  end
               end
               REQ_READ: begin
                  if (rd_in_range) begin
                     rd_en    = 1'b1;
                     rd_addr  = {ROW_W'(rrow_ff), COL_W'(rcol_ff)};
                     state_in = S_READ;
                  end else begin
                     state_in = S_DONE;
                  end
               end
               default: begin
                  state_in = S_DONE;
               end
            endcase
         end
         S_READ: begin
            cell_in  = rd_data;
            state_in = S_DONE;
         end
         S_SCR_RD: begin
            rd_en    = 1'b1;
            rd_addr  = {scr_row_ff, scr_col_ff};
            state_in = S_SCR_WR;
         end
         S_SCR_WR: begin
            // copy the cell one row up, then step along the row and down the screen
            wr_en    = 1'b1;
            wr_addr  = {scr_row_ff - 1'b1, scr_col_ff};
            wr_data  = rd_data;
            state_in = S_SCR_RD;
            if (scr_col_ff == cols_m1) begin
               scr_col_in = '0;
               if (scr_row_ff == rows_m1) begin
                  state_in = S_BLANK;
               end else begin
                  scr_row_in = scr_row_ff + 1'b1;
               end
            end else begin
               scr_col_in = scr_col_ff + 1'b1;
            end
         end
         S_BLANK: begin
            wr_en   = 1'b1;
            wr_addr = {rows_m1, scr_col_ff};
            wr_data = {cfg.attr, SPACE_CODE};
            if (scr_col_ff == cols_m1) begin
               // whole screen goes dirty after a scroll
               dcmd.mark  = 1'b1;
               mark_x_end = cols_eff;
               mark_y_end = rows_eff;
               state_in   = S_MARK_PREV;
            end else begin
               scr_col_in = scr_col_ff + 1'b1;
            end
         end
         S_MARK_PREV: begin
            dcmd.mark  = 1'b1;
            mark_x     = prev_x_ff;
            mark_y     = prev_y_ff;
            mark_x_end = CX_W'(prev_x_ff) + 1'b1;
            mark_y_end = CY_W'(prev_y_ff) + 1'b1;
            state_in   = S_MARK_NEW;
         end
         S_MARK_NEW: begin
            dcmd.mark  = 1'b1;
            mark_x     = cursor_x_ff;
            mark_y     = cursor_y_ff;
            mark_x_end = CX_W'(cursor_x_ff) + 1'b1;
            mark_y_end = CY_W'(cursor_y_ff) + 1'b1;
            prev_x_in  = cursor_x_ff;
            prev_y_in  = cursor_y_ff;
            state_in   = S_DONE;
         end
         S_DONE: begin
            // the result shows the rectangle before a take empties it
            if (out_load) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {4'b0,
                               (d_right != '0) || (d_bottom != '0),
                               7'(d_bottom), 8'(d_right), 7'(d_top), 8'(d_left),
                               cell_ff, 6'(cursor_y_ff), 7'(cursor_x_ff)};
               dcmd.clear   = (type_ff == REQ_TAKE);
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_addr_ff  <= '0;
         cursor_x_ff  <= '0;
         cursor_y_ff  <= '0;
         prev_x_ff    <= '0;
         prev_y_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         cursor_x_ff  <= cursor_x_in;
         cursor_y_ff  <= cursor_y_in;
         prev_x_ff    <= prev_x_in;
         prev_y_ff    <= prev_y_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      type_ff     <= type_in;
      char_ff     <= char_in;
      rcol_ff     <= rcol_in;
      rrow_ff     <= rrow_in;
      scr_col_ff  <= scr_col_in;
      scr_row_ff  <= scr_row_in;
      cell_ff     <= cell_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

/* rtl/core/tcw_ram.sv */
// generic single-write, single-read ram with registered read data
module tcw_ram
   #(
      parameter int WIDTH = 16,
      parameter int DEPTH = 8192
   )
   (
      input  logic                     clock,
      input  logic                     wr_en,
      input  logic [$clog2(DEPTH)-1:0] wr_addr,
      input  logic [WIDTH-1:0]         wr_data,
      input  logic                     rd_en,
      input  logic [$clog2(DEPTH)-1:0] rd_addr,
      output logic [WIDTH-1:0]         rd_data
   );

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/core/tcw_csr.sv */
// configuration registers behind the apb-style port
module tcw_csr
   import tcw_pkg::*;
   (
      input  logic                  clock,
      input  logic                  reset,
      input  logic                  psel,
      input  logic                  penable,
      input  logic                  pwrite,
      input  logic [CSR_ADDR_W-1:0] paddr,
      input  logic [31:0]           pwdata,
      output logic [31:0]           prdata,
      output logic                  pready,
      output cfg_type               cfg
   );

   cfg_type    cfg_ff;
   cfg_type    cfg_in;
   logic       wr_stb;
   logic [1:0] reg_idx;

   assign pready  = 1'b1;
   assign reg_idx = paddr[3:2];
   assign wr_stb  = psel && penable && pwrite && pready;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_stb) begin
         case (reg_idx)
            REG_COLS: cfg_in.cols = pwdata[7:0];
            REG_ROWS: cfg_in.rows = pwdata[6:0];
            REG_ATTR: cfg_in.attr = pwdata[7:0];
            default:  cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.cols <= 8'(RESET_COLS);
         cfg_ff.rows <= 7'(RESET_ROWS);
         cfg_ff.attr <= RESET_ATTR;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      case (reg_idx)
         REG_COLS: prdata = {24'b0, cfg_ff.cols};
         REG_ROWS: prdata = {25'b0, cfg_ff.rows};
         REG_ATTR: prdata = {24'b0, cfg_ff.attr};
         default:  prdata = 32'b0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule

/* rtl/core/tcw_dirty.sv */
// dirty rectangle: one merge or empty per cycle through per-edge min/max compares; an empty wins over a merge
module tcw_dirty
   import tcw_pkg::*;
   #(
      parameter int MAX_COLUMNS = DEF_MAX_COLUMNS,
      parameter int MAX_ROWS    = DEF_MAX_ROWS
   )
   (
      input  logic                          clock,
      input  logic                          reset,
      input  dirty_cmd_type                 cmd,
      input  logic [$clog2(MAX_COLUMNS)-1:0] mark_x,
      input  logic [$clog2(MAX_ROWS)-1:0]    mark_y,
      input  logic [$clog2(MAX_COLUMNS):0]   mark_x_end,
      input  logic [$clog2(MAX_ROWS):0]      mark_y_end,
      output logic [$clog2(MAX_COLUMNS):0]   left,
      output logic [$clog2(MAX_ROWS):0]      top,
      output logic [$clog2(MAX_COLUMNS):0]   right,
      output logic [$clog2(MAX_ROWS):0]      bottom
   );

   localparam int COL_W    = $clog2(MAX_COLUMNS);
   localparam int ROW_W    = $clog2(MAX_ROWS);
   localparam int CX_W     = COL_W + 1;
   localparam int CY_W     = ROW_W + 1;
   localparam int RST_COLS = (RESET_COLS > MAX_COLUMNS) ? MAX_COLUMNS : RESET_COLS;
   localparam int RST_ROWS = (RESET_ROWS > MAX_ROWS) ? MAX_ROWS : RESET_ROWS;

   logic [CX_W-1:0] left_ff, left_in, right_ff, right_in;
   logic [CY_W-1:0] top_ff, top_in, bottom_ff, bottom_in;

   always_comb begin
      left_in   = left_ff;
      top_in    = top_ff;
      right_in  = right_ff;
      bottom_in = bottom_ff;
      if (cmd.clear) begin
         left_in   = CX_W'(MAX_COLUMNS);
         top_in    = CY_W'(MAX_ROWS);
         right_in  = '0;
         bottom_in = '0;
      end else if (cmd.mark) begin
         if ({1'b0, mark_x} < left_ff) left_in = {1'b0, mark_x};
         if ({1'b0, mark_y} < top_ff) top_in = {1'b0, mark_y};
         if (mark_x_end > right_ff) right_in = mark_x_end;
         if (mark_y_end > bottom_ff) bottom_in = mark_y_end;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff   <= '0;
         top_ff    <= '0;
         right_ff  <= CX_W'(RST_COLS);
         bottom_ff <= CY_W'(RST_ROWS);
      end else begin
         left_ff   <= left_in;
         top_ff    <= top_in;
         right_ff  <= right_in;
         bottom_ff <= bottom_in;
      end
   end

   assign left   = left_ff;
   assign top    = top_ff;
   assign right  = right_ff;
   assign bottom = bottom_ff;

endmodule
